// ===== design/kvls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvls_pkg
// Shared types, codes and character helpers for the key/value line splitter.
// ----------------------------------------------------------------------------
package kvls_pkg;

  localparam int MAX_LINE = 1024;
  localparam int CNT_W    = $clog2(MAX_LINE + 1);

  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 10;
  localparam int STAT_W = 3;
  localparam int LEN_W  = 11;

  localparam logic [KIND_W-1:0] KIND_KEY    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VAL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_COLON    = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_KEY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY_VALUE = 3'd3;
  localparam logic [STAT_W-1:0] ST_TOO_LONG    = 3'd4;

  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] char_out;
    logic [POS_W-1:0]  position;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  key_length;
    logic [LEN_W-1:0]  value_length;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_LEAD  = 4'b0001,
    PH_KEY   = 4'b0010,
    PH_VLEAD = 4'b0100,
    PH_VAL   = 4'b1000
  } phase_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_numeral(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ===== design/key_value_line_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_line_splitter
// Splits a dictionary line, one character per item, into key and value.
// ----------------------------------------------------------------------------
// Usage:
//   in_item carries one line character, or the end-of-line marker, per item;
//   an item moves when in_valid is high and in_stall is low. Each character
//   yields at most one out_item: a key character, a value character, or on
//   end of line a report with trimmed key/value lengths and a status.
//   Leading blanks, the first colon and blanks after it produce no item, nor
//   do characters beyond MAX_LINE in the key or value.
//   Throughput: one item per cycle while out_stall is low. An accepted item
//   lands in the input register; its result, if any, moves on into the
//   output register once that is empty or being drained, and out_valid
//   rises with it. The line state is updated in the same cycle the item
//   leaves the input register, which sets the one-item-per-cycle figure.
//   When out_stall is high with a result waiting, the input register holds
//   and in_stall rises once it is full; nothing is dropped.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   line state to leading whitespace with all counts zero. After each
//   report the line state returns to that same state.
// ----------------------------------------------------------------------------
module key_value_line_splitter
  import kvls_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LINE);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  phase_t           phase_r,         phase_nxt;
  logic [CNT_W-1:0] key_count_r,     key_count_nxt;
  logic [CNT_W-1:0] key_trimmed_r,   key_trimmed_nxt;
  logic [CNT_W-1:0] value_count_r,   value_count_nxt;
  logic [CNT_W-1:0] value_trimmed_r, value_trimmed_nxt;
  logic             first_zero_r,    first_zero_nxt;
  logic             key_bad_r,       key_bad_nxt;
  logic             space_pend_r,    space_pend_nxt;
  logic             overflow_r,      overflow_nxt;

  logic      advance;
  logic      emit;
  out_item_t res;
  logic      take_key;
  logic      take_val;
  logic      colon_seen;
  logic      bad_key;
  logic [CHAR_W-1:0] c;

  // Stage 1 moves on whenever the output register is empty or being drained.
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign c         = s1_item_r.char_in;

  always_comb begin
    phase_nxt         = phase_r;
    key_count_nxt     = key_count_r;
    key_trimmed_nxt   = key_trimmed_r;
    value_count_nxt   = value_count_r;
    value_trimmed_nxt = value_trimmed_r;
    first_zero_nxt    = first_zero_r;
    key_bad_nxt       = key_bad_r;
    space_pend_nxt    = space_pend_r;
    overflow_nxt      = overflow_r;
    emit              = 1'b0;
    take_key          = 1'b0;
    take_val          = 1'b0;
    res               = '0;

    colon_seen = (phase_r == PH_VLEAD) || (phase_r == PH_VAL);
    bad_key    = key_bad_r || (key_trimmed_r == '0) ||
                 (first_zero_r && (key_trimmed_r > CNT_ONE));

    if (s1_valid_r && advance) begin
      if (s1_item_r.end_of_line) begin
        emit         = 1'b1;
        res.kind     = KIND_REPORT;
        res.key_length = LEN_W'(key_trimmed_r);
        res.value_length = colon_seen ? LEN_W'(value_trimmed_r) : '0;
        priority if (overflow_r) begin
          res.status = ST_TOO_LONG;
        end else if (!colon_seen) begin
          res.status = ST_NO_COLON;
        end else if (bad_key) begin
          res.status = ST_BAD_KEY;
        end else if (value_trimmed_r == '0) begin
          res.status = ST_EMPTY_VALUE;
        end else begin
          res.status = ST_OK;
        end
        // Clear the line state for the next line.
        phase_nxt         = PH_LEAD;
        key_count_nxt     = '0;
        key_trimmed_nxt   = '0;
        value_count_nxt   = '0;
        value_trimmed_nxt = '0;
        first_zero_nxt    = 1'b0;
        key_bad_nxt       = 1'b0;
        space_pend_nxt    = 1'b0;
        overflow_nxt      = 1'b0;
      end else begin
        unique case (phase_r)
          PH_LEAD: begin
            if (c == CH_COLON) begin
              phase_nxt = PH_VLEAD;
            end else if (!is_blank(c)) begin
              phase_nxt = PH_KEY;
              take_key  = 1'b1;
            end
          end
          PH_KEY: begin
            if (c == CH_COLON) begin
              phase_nxt = PH_VLEAD;
            end else begin
              take_key = 1'b1;
            end
          end
          PH_VLEAD: begin
            if (!is_blank(c)) begin
              phase_nxt = PH_VAL;
              take_val  = 1'b1;
            end
          end
          PH_VAL: begin
            take_val = 1'b1;
          end
          default: begin
            phase_nxt = PH_LEAD;
          end
        endcase

        if (take_key) begin
          if (key_count_r == CNT_MAX) begin
            overflow_nxt = 1'b1;   // drop the character
          end else begin
            if (is_blank(c)) begin
              space_pend_nxt = 1'b1;
            end else begin
              if (space_pend_r || !is_numeral(c)) begin
                key_bad_nxt = 1'b1;
              end
              if ((key_count_r == '0) && (c == CH_ZERO)) begin
                first_zero_nxt = 1'b1;
              end
              key_trimmed_nxt = key_count_r + CNT_ONE;
            end
            emit          = 1'b1;
            res.kind      = KIND_KEY;
            res.char_out  = c;
            res.position  = POS_W'(key_count_r);
            key_count_nxt = key_count_r + CNT_ONE;
          end
        end

        if (take_val) begin
          if (value_count_r == CNT_MAX) begin
            overflow_nxt = 1'b1;   // drop the character
          end else begin
            if (!is_blank(c)) begin
              value_trimmed_nxt = value_count_r + CNT_ONE;
            end
            emit            = 1'b1;
            res.kind        = KIND_VAL;
            res.char_out    = c;
            res.position    = POS_W'(value_count_r);
            value_count_nxt = value_count_r + CNT_ONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      phase_r         <= PH_LEAD;
      key_count_r     <= '0;
      key_trimmed_r   <= '0;
      value_count_r   <= '0;
      value_trimmed_r <= '0;
      first_zero_r    <= 1'b0;
      key_bad_r       <= 1'b0;
      space_pend_r    <= 1'b0;
      overflow_r      <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= emit;
      end
      phase_r         <= phase_nxt;
      key_count_r     <= key_count_nxt;
      key_trimmed_r   <= key_trimmed_nxt;
      value_count_r   <= value_count_nxt;
      value_trimmed_r <= value_trimmed_nxt;
      first_zero_r    <= first_zero_nxt;
      key_bad_r       <= key_bad_nxt;
      space_pend_r    <= space_pend_nxt;
      overflow_r      <= overflow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
    if (advance && emit) begin
      out_item_r <= res;
    end
  end

endmodule

// ===== tb/key_value_line_splitter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_line_splitter_test
// Self-checking bench for the key/value line splitter. A line model in the
// bench predicts every key character, value character and end-of-line report
// from the accepted input items. Each accepted output item is checked in
// order against those predictions. The stimulus has three parts: short
// directed lines for the status cases, one overlong line, and random lines
// under several idle and stall mixes, one of which includes a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module key_value_line_splitter_test;
  import kvls_pkg::*;

  // Line model plus queue of predicted output items.
  class kv_line_tracker;
    out_item_t pending_items[$];
    int        errors;
    phase_t    phase;
    int        key_count;
    int        key_trimmed;
    int        value_count;
    int        value_trimmed;
    bit        first_is_zero;
    bit        key_bad;
    bit        space_pending;
    bit        overflowed;

    function new();
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase         = PH_LEAD;
      key_count     = 0;
      key_trimmed   = 0;
      value_count   = 0;
      value_trimmed = 0;
      first_is_zero = 1'b0;
      key_bad       = 1'b0;
      space_pending = 1'b0;
      overflowed    = 1'b0;
    endfunction

    function bit blank_char(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function bit take_key(input logic [CHAR_W-1:0] c, output out_item_t r);
      r = '0;
      // drop the character once the key is full
      if (key_count >= MAX_LINE) begin
        overflowed = 1'b1;
        return 1'b0;
      end
      if (blank_char(c)) begin
        space_pending = 1'b1;
      end else begin
        if (space_pending || c < CH_ZERO || c > CH_NINE) key_bad = 1'b1;
        if (key_count == 0 && c == CH_ZERO) first_is_zero = 1'b1;
        key_trimmed = key_count + 1;
      end
      r.kind     = KIND_KEY;
      r.char_out = c;
      r.position = POS_W'(key_count);
      key_count++;
      return 1'b1;
    endfunction

    function bit take_value(input logic [CHAR_W-1:0] c, output out_item_t r);
      r = '0;
      if (value_count >= MAX_LINE) begin
        overflowed = 1'b1;
        return 1'b0;
      end
      if (!blank_char(c)) value_trimmed = value_count + 1;
      r.kind     = KIND_VAL;
      r.char_out = c;
      r.position = POS_W'(value_count);
      value_count++;
      return 1'b1;
    endfunction

    function void note_char(input in_item_t it);
      out_item_t         r;
      bit                got;
      bit                colon_seen;
      bit                bad;
      logic [CHAR_W-1:0] c;
      c   = it.char_in;
      got = 1'b0;
      r   = '0;
      if (it.end_of_line) begin
        colon_seen = (phase == PH_VLEAD) || (phase == PH_VAL);
        bad = key_bad || key_trimmed == 0 || (first_is_zero && key_trimmed > 1);
        r.kind = KIND_REPORT;
        if (overflowed) r.status = ST_TOO_LONG;
        else if (!colon_seen) r.status = ST_NO_COLON;
        else if (bad) r.status = ST_BAD_KEY;
        else if (value_trimmed == 0) r.status = ST_EMPTY_VALUE;
        else r.status = ST_OK;
        r.key_length   = LEN_W'(key_trimmed);
        r.value_length = colon_seen ? LEN_W'(value_trimmed) : '0;
        got = 1'b1;
        clear_line();
      end else begin
        case (phase)
          PH_LEAD: begin
            if (blank_char(c)) begin
              got = 1'b0;
            end else if (c == CH_COLON) begin
              phase = PH_VLEAD;
            end else begin
              phase = PH_KEY;
              got = take_key(c, r);
            end
          end
          PH_KEY: begin
            if (c == CH_COLON) phase = PH_VLEAD;
            else got = take_key(c, r);
          end
          PH_VLEAD: begin
            if (!blank_char(c)) begin
              phase = PH_VAL;
              got = take_value(c, r);
            end
          end
          default: got = take_value(c, r);
        endcase
      end
      if (got) pending_items.push_back(r);
    endfunction

    function void compare(input string name, input int unsigned want_v,
                          input int unsigned got_v);
      if (want_v != got_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                 want_v, got_v);
        errors++;
      end
    endfunction

    function void check_item(input out_item_t got_item);
      out_item_t want;
      if (pending_items.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual kind %0d char %0h",
                 $time, got_item.kind, got_item.char_out);
        errors++;
        return;
      end
      want = pending_items.pop_front();
      compare("kind", want.kind, got_item.kind);
      compare("char_out", want.char_out, got_item.char_out);
      compare("position", want.position, got_item.position);
      compare("status", want.status, got_item.status);
      compare("key_length", want.key_length, got_item.key_length);
      compare("value_length", want.value_length, got_item.value_length);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int             send_idle_pct;
  int             recv_stall_pct;
  bit             hold_req;
  int             sent_count;
  kv_line_tracker tracker;

  key_value_line_splitter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Entered and left at a falling edge.
  task automatic send_item(input in_item_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= x;
    do @(posedge clk); while (in_stall);
    tracker.note_char(x);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] c);
    in_item_t x;
    x.char_in     = c;
    x.end_of_line = 1'b0;
    send_item(x);
  endtask

  task automatic send_eol(input logic [CHAR_W-1:0] c);
    in_item_t x;
    x.char_in     = c;
    x.end_of_line = 1'b1;
    send_item(x);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [CHAR_W-1:0] pick_blank();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // Mostly well-formed lines with random content, the rest noise.
  task automatic send_random_line();
    int                n;
    int                roll;
    logic [CHAR_W-1:0] c;
    if ($urandom_range(99) < 80) begin
      repeat ($urandom_range(2)) send_char(pick_blank());
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) begin
        roll = $urandom_range(99);
        if (i == 0 && roll < 10) c = CH_ZERO;
        else if (roll < 14) c = CHAR_W'($urandom_range(255));
        else if (i > 0 && roll < 19) c = pick_blank();
        else c = CH_ZERO + CHAR_W'($urandom_range(9));
        send_char(c);
      end
      repeat ($urandom_range(2)) send_char(pick_blank());
      if ($urandom_range(99) < 92) send_char(CH_COLON);
      repeat ($urandom_range(2)) send_char(pick_blank());
      n = $urandom_range(6);
      for (int i = 0; i < n; i++) begin
        roll = $urandom_range(99);
        if (roll < 15) c = pick_blank();
        else if (roll < 22) c = CH_COLON;
        else c = CHAR_W'($urandom_range(255));
        send_char(c);
      end
      repeat ($urandom_range(2)) send_char(pick_blank());
    end else begin
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++) begin
        roll = $urandom_range(99);
        if (roll < 25) c = pick_blank();
        else if (roll < 40) c = CH_COLON;
        else if (roll < 55) c = CH_ZERO + CHAR_W'($urandom_range(9));
        else c = CHAR_W'($urandom_range(255));
        send_char(c);
      end
    end
    send_eol(CHAR_W'($urandom_range(255)));
  endtask

  // Receiver: random stall, plus a long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 300;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_item(out_item);
  end

  initial begin : stimulus
    int start;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    sent_count     = 0;
    tracker        = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed lines
    send_text("0:");
    send_char(8'hFF);
    send_eol(8'hFF);
    send_text("01:7");
    send_eol(8'h00);
    send_text(":");
    send_char(8'h00);
    send_eol(8'h00);
    send_text("42");
    send_eol(CH_COLON);
    send_text("\t5 :\na: ");
    send_eol(8'h00);
    send_text("3:");
    send_char(CH_CR);
    send_eol(8'h00);
    send_text("1 2:");
    send_eol(8'h00);

    // overlong value with inner blanks
    send_text("7:");
    for (int i = 0; i < 1026; i++) begin
      send_char((i % 7 == 6) ? CH_TAB : 8'h41 + CHAR_W'(i % 26));
    end
    send_eol(8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          send_idle_pct  = 86;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 86;
        end
        default: begin
          send_idle_pct  = 32;
          recv_stall_pct = 32;
        end
      endcase
      start = sent_count;
      while (sent_count - start < 140) send_random_line();
    end

    in_valid <= 1'b0;
    while (tracker.pending_items.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_items.size() == 0) begin
      $display("key_value_line_splitter regression: pass");
    end else begin
      $display("key_value_line_splitter regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("key_value_line_splitter regression: fail");
    $finish;
  end

endmodule

// ===== key_value_line_splitter.f =====
design/kvls_pkg.sv
design/key_value_line_splitter.sv
tb/key_value_line_splitter_test.sv
